// ===== rtl/gbrp_pkg.sv =====
package gbrp_pkg;

	localparam int unsigned MAX_NEST_DEF = 15;

	localparam logic [4:0] PH_OUT        = 5'd0;
	localparam logic [4:0] PH_OPC        = 5'd1;
	localparam logic [4:0] PH_T5         = 5'd2;
	localparam logic [4:0] PH_T1_DST     = 5'd3;
	localparam logic [4:0] PH_T1_SRC     = 5'd4;
	localparam logic [4:0] PH_MV_CNT     = 5'd5;
	localparam logic [4:0] PH_MV_DST     = 5'd6;
	localparam logic [4:0] PH_MV_SRC     = 5'd7;
	localparam logic [4:0] PH_MV_IDX     = 5'd8;
	localparam logic [4:0] PH_ONE        = 5'd9;
	localparam logic [4:0] PH_BRBS       = 5'd10;
	localparam logic [4:0] PH_B_WORD     = 5'd11;
	localparam logic [4:0] PH_CALL_WORD  = 5'd12;
	localparam logic [4:0] PH_CALL_DWORD = 5'd13;
	localparam logic [4:0] PH_CALL_DBYTE = 5'd14;
	localparam logic [4:0] PH_FMT_CTRL   = 5'd15;
	localparam logic [4:0] PH_FMT_DATA   = 5'd16;
	localparam logic [4:0] PH_FMT_LOOP   = 5'd17;

	localparam logic [2:0] K_ARG   = 3'd1;
	localparam logic [2:0] K_FIXED = 3'd2;
	localparam logic [2:0] K_WORD  = 3'd3;
	localparam logic [2:0] K_OTHER = 3'd4;

	localparam logic [2:0] ROLE_OPC   = 3'd0;
	localparam logic [2:0] ROLE_OPND  = 3'd1;
	localparam logic [2:0] ROLE_RHI   = 3'd2;
	localparam logic [2:0] ROLE_RLO   = 3'd3;
	localparam logic [2:0] ROLE_FCTL  = 3'd4;
	localparam logic [2:0] ROLE_FDATA = 3'd5;
	localparam logic [2:0] ROLE_OUTP  = 3'd6;

	localparam logic [0:0] REG_SRC_BASE  = 1'd0;
	localparam logic [0:0] REG_DEST_BASE = 1'd1;

	localparam logic [15:0] SRC_BASE_RST  = 16'h6000;
	localparam logic [15:0] DEST_BASE_RST = 16'h2000;

	// One decoded result pair: first (high byte) is only used for address words.
	typedef struct packed {
		logic        two;
		logic [7:0]  hi_byte;
		logic [7:0]  out_byte;
		logic [2:0]  byte_role;
		logic        path_end;
		logic        target_valid;
		logic [15:0] target_addr;
		logic        range_warning;
	} res_t;

	function automatic logic [5:0] arg_len(input logic [7:0] b);
		if (!b[7]) return 6'd1;
		if (!b[6]) return (b[3:0] == 4'hf) ? 6'd3 : 6'd2;
		return (b[3:0] == 4'hf) ? 6'd4 : 6'd3;
	endfunction

	function automatic logic [2:0] kind_of(input logic [4:0] ph, input logic [7:0] op,
			output logic [5:0] len);
		len = 6'd1;
		case (ph)
			PH_T5, PH_T1_DST: return K_ARG;
			PH_T1_SRC: begin
				if (op[1]) begin
					len = op[0] ? 6'd2 : 6'd1;
					return K_FIXED;
				end
				return K_ARG;
			end
			PH_MV_CNT: begin
				if (op[0]) begin
					len = 6'd2;
					return K_FIXED;
				end
				return K_ARG;
			end
			PH_MV_DST: begin
				if (op[3]) return K_FIXED;
				return op[4] ? K_ARG : K_WORD;
			end
			PH_MV_SRC: return op[2] ? K_ARG : K_WORD;
			PH_MV_IDX, PH_ONE, PH_CALL_DBYTE: return K_FIXED;
			PH_B_WORD, PH_CALL_WORD, PH_CALL_DWORD, PH_FMT_LOOP: return K_WORD;
			default: return K_OTHER;
		endcase
	endfunction

	function automatic logic [4:0] succ(input logic [4:0] ph);
		case (ph)
			PH_T1_DST: return PH_T1_SRC;
			PH_MV_CNT: return PH_MV_DST;
			PH_MV_DST: return PH_MV_SRC;
			PH_MV_SRC: return PH_MV_IDX;
			default:   return PH_OPC;
		endcase
	endfunction

	function automatic logic is_endpath(input logic [7:0] op);
		if (op <= 8'h0f) return (op <= 8'h02) || (op == 8'h0b);
		if (op <= 8'h1f) return 1'b1;
		if (op >= 8'h98 && op <= 8'h9f) return 1'b1;
		if (op >= 8'hf0 && op <= 8'hf3) return 1'b1;
		return op >= 8'hfc;
	endfunction

endpackage

// ===== rtl/gpl_bytecode_relocation_parser.sv =====
// Channel | Dir | Content
// s_axis  | in  | tdata: code_byte[7:0], path_start[8]
// m_axis  | out | tdata: out_byte, byte_role, path_end, target_valid, target_addr,
//         |     |        range_warning, last_result
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// One byte is accepted per cycle while output is free; results leave next cycle.
// An address word low byte gives two items; input waits until the high byte goes.
// Reset (arst_n) clears parse state and loads the default bases.
// A stalled output holds its item and the input waits.
module gpl_bytecode_relocation_parser
	import gbrp_pkg::*;
#(
	parameter int unsigned MAX_NEST = MAX_NEST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // code_byte[7:0], path_start[8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_byte, byte_role, path_end, target_valid,
	                                   // target_addr, range_warning, last_result
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);

	logic [15:0] src_q, dest_q;
	res_t        res;
	logic        held;
	logic        step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_BASE_RST; dest_q <= DEST_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SRC_BASE:  src_q <= cfg_data;
				REG_DEST_BASE: dest_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step = s_axis_tvalid && s_axis_tready;

	gbrp_core #(.MAX_NEST(MAX_NEST)) u_core (
		.clk, .arst_n, .step,
		.code_byte(s_axis_tdata[7:0]), .path_start(s_axis_tdata[8]),
		.src_base(src_q), .dest_base(dest_q), .res, .held
	);

	gbrp_out u_out (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.hold_only(held),
		.res, .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata)
	);

	logic unused_ok;
	assign unused_ok = ^s_axis_tdata[15:9];

endmodule

// ===== rtl/gbrp_core.sv =====
module gbrp_core
	import gbrp_pkg::*;
#(
	parameter int unsigned MAX_NEST = MAX_NEST_DEF,
	localparam int unsigned NW = $clog2(MAX_NEST + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  code_byte,
	input  logic        path_start,
	input  logic [15:0] src_base,
	input  logic [15:0] dest_base,
	output res_t        res,
	output logic        held
);

	logic [4:0]    phase_q;
	logic [7:0]    opc_q;
	logic [5:0]    rem_q;
	logic [7:0]    hold_q;
	logic [15:0]   call_q;
	logic [1:0]    flags_q;
	logic [NW-1:0] nest_q;

	logic [4:0]    ph, ph_n;
	logic [7:0]    opc, opc_n;
	logic [5:0]    rem, rem_n, len;
	logic [7:0]    hold, hold_n;
	logic [15:0]   call_n;
	logic [1:0]    flags, flags_n;
	logic [NW-1:0] nest, nest_n;
	logic [2:0]    kind;
	logic [15:0]   w, nv, patched;
	logic          warn, end_w, do_patch;
	logic [4:0]    nxt;

	// Sets the phase and the fixed byte count for a new step.
	function automatic void enter(input logic [4:0] p, input logic [7:0] op,
			output logic [4:0] po, output logic [5:0] ro);
		logic [5:0] l;
		logic [2:0] k;
		po = (p == PH_MV_IDX && !op[1]) ? PH_OPC : p;
		k = kind_of(po, op, l);
		ro = (k == K_FIXED) ? l : 6'd0;
	endfunction

	assign w = {hold, code_byte};
	assign patched = w - src_base + dest_base;

	always_comb begin
		ph = phase_q; opc = opc_q; rem = rem_q; hold = hold_q;
		flags = flags_q; nest = nest_q;
		if (path_start) begin
			flags = 2'b11; nest = '0; rem = '0; hold = '0; ph = PH_OPC;
		end
		ph_n = ph; opc_n = opc; rem_n = rem; hold_n = hold; call_n = call_q;
		flags_n = flags; nest_n = nest;
		res = '0;
		res.out_byte = code_byte;
		held = 1'b0;
		kind = kind_of(ph, opc, len);
		warn = 1'b0; end_w = 1'b0; do_patch = 1'b0; nv = w; nxt = PH_OPC;
		case (ph)
			PH_OPC: begin
				opc_n = code_byte;
				res.byte_role = ROLE_OPC;
				if (is_endpath(code_byte)) begin
					res.path_end = 1'b1;
					ph_n = PH_OUT;
				end else begin
					if ((code_byte >= 8'hc4 && code_byte <= 8'hdb) ||
							(code_byte >= 8'hec && code_byte <= 8'hef) ||
							code_byte == 8'h8a || code_byte == 8'h8b ||
							code_byte == 8'h8e || code_byte == 8'h8f ||
							code_byte == 8'h03 || code_byte == 8'h09 ||
							code_byte == 8'h0a || code_byte == 8'h0c ||
							code_byte == 8'h0d || code_byte == 8'h0f)
						flags_n = 2'b11;
					if (code_byte == 8'h04 || code_byte == 8'h07 ||
							code_byte == 8'h0e || code_byte == 8'h0f)
						nxt = PH_ONE;
					else if (code_byte == 8'h05) begin
						flags_n = 2'b10; nxt = PH_B_WORD;
					end else if (code_byte == 8'h06) begin
						flags_n = 2'b00; nxt = PH_CALL_WORD;
					end else if (code_byte == 8'h08) begin
						nest_n = '0; nxt = PH_FMT_CTRL;
					end else if (code_byte >= 8'h20 && code_byte <= 8'h3f) nxt = PH_MV_CNT;
					else if (code_byte >= 8'h40 && code_byte <= 8'h7f) nxt = PH_BRBS;
					else if (code_byte >= 8'h80 && code_byte <= 8'h97) nxt = PH_T5;
					else if (code_byte >= 8'ha0) nxt = PH_T1_DST;
					enter(nxt, code_byte, ph_n, rem_n);
				end
			end
			PH_BRBS: begin
				flags_n = (opc[7:5] == 3'b010) ? (flags & 2'b01) : (flags & 2'b10);
				res.byte_role = ROLE_OPND;
				res.path_end = (flags_n == 2'b00);
				res.target_valid = 1'b1;
				res.target_addr = {3'b000, opc[4:0], code_byte} + src_base;
				ph_n = (flags_n == 2'b00) ? PH_OUT : PH_OPC;
			end
			PH_FMT_CTRL: begin
				res.byte_role = ROLE_FCTL;
				case (code_byte[7:5])
					3'b000, 3'b001: begin
						ph_n = PH_FMT_DATA; rem_n = {1'b0, code_byte[4:0]} + 6'd1;
					end
					3'b010, 3'b011: begin
						ph_n = PH_FMT_DATA; rem_n = 6'd1;
					end
					3'b100, 3'b101: ;
					3'b110: begin
						if (nest < NW'(MAX_NEST)) nest_n = nest + 1'b1;
					end
					default: begin
						if (code_byte == 8'hfb) begin
							if (nest != '0) begin
								nest_n = nest - 1'b1;
								enter(PH_FMT_LOOP, opc, ph_n, rem_n);
							end else enter(PH_OPC, opc, ph_n, rem_n);
						end else if (code_byte != 8'hfc) begin
							ph_n = PH_FMT_DATA; rem_n = 6'd1;
						end
					end
				endcase
			end
			PH_FMT_DATA: begin
				res.byte_role = ROLE_FDATA;
				rem_n = (rem != 6'd0) ? rem - 6'd1 : rem;
				if (rem_n == 6'd0) ph_n = PH_FMT_CTRL;
			end
			default: begin
				if (kind == K_OTHER) begin
					ph_n = PH_OUT;
					res.byte_role = ROLE_OUTP;
				end else if (kind == K_WORD) begin
					if (rem == 6'd0) begin
						hold_n = code_byte; rem_n = 6'd1;
						held = 1'b1;
						res.two = 1'b0;
						res.byte_role = ROLE_OUTP;
					end else begin
						rem_n = 6'd0;
						case (ph)
							PH_B_WORD: begin
								if (w > src_base) begin
									do_patch = 1'b1;
									res.target_valid = 1'b1; res.target_addr = w;
								end
								end_w = 1'b1;
							end
							PH_CALL_WORD: begin
								call_n = w;
								if (w > src_base) begin
									do_patch = 1'b1;
									res.target_valid = 1'b1; res.target_addr = w;
									nxt = (w == 16'h69d0 || w == 16'h69c4 || w == 16'h65b2)
										? PH_CALL_DWORD : PH_OPC;
								end else if (w == 16'h0010 || w == 16'h14a9 ||
										w == 16'h1499 || w == 16'h149f || w == 16'h14fe)
									nxt = PH_CALL_DBYTE;
								else nxt = (w == 16'h001c) ? PH_CALL_DWORD : PH_OPC;
							end
							PH_FMT_LOOP: begin
								do_patch = (w > src_base);
								nxt = PH_FMT_CTRL;
							end
							default: begin
								do_patch = 1'b1;
								nxt = succ(ph);
							end
						endcase
						if (do_patch) begin
							if (w >= src_base) nv = patched;
							else if (w >= dest_base) warn = 1'b1;
						end
						res.two = 1'b1;
						res.hi_byte = nv[15:8];
						res.out_byte = nv[7:0];
						res.byte_role = ROLE_RLO;
						res.path_end = end_w;
						res.range_warning = warn;
						if (end_w) ph_n = PH_OUT;
						else enter(nxt, opc, ph_n, rem_n);
					end
				end else begin
					res.byte_role = ROLE_OPND;
					if (kind == K_ARG && rem == 6'd0) rem_n = arg_len(code_byte) - 6'd1;
					else if (rem != 6'd0) rem_n = rem - 6'd1;
					if (rem_n == 6'd0) enter(succ(ph), opc, ph_n, rem_n);
				end
			end
		endcase
		if (ph == PH_OUT) begin
			res = '0;
			res.out_byte = code_byte;
			res.byte_role = ROLE_OUTP;
			ph_n = PH_OUT;
		end
	end

	// A held high byte is the only case with no result; it is flagged by held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OUT; opc_q <= '0; rem_q <= '0; hold_q <= '0;
			call_q <= '0; flags_q <= 2'b11; nest_q <= '0;
		end else if (step) begin
			phase_q <= ph_n; opc_q <= opc_n; rem_q <= rem_n; hold_q <= hold_n;
			call_q <= call_n; flags_q <= flags_n; nest_q <= nest_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) nest_q <= NW'(MAX_NEST))
		else $error("nesting beyond bound");
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_FMT_LOOP) else $error("bad phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 6'd32) else $error("byte count beyond bound");

endmodule

// ===== rtl/gbrp_out.sv =====
module gbrp_out
	import gbrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        hold_only,
	input  res_t        res,
	output logic        m_valid,
	input  logic        m_ready,
	output logic [31:0] m_data
);

	// Single-entry result buffer; a word's entry holds both bytes and is sent as two items, high byte first.
	res_t        r_q;
	logic        v_q, hi_q;

	assign in_ready = !v_q || (m_ready && !hi_q);
	assign m_valid = v_q;

	always_comb begin
		m_data = '0;
		if (hi_q) begin
			m_data[7:0]  = r_q.hi_byte;
			m_data[10:8] = ROLE_RHI;
		end else begin
			m_data[7:0]   = r_q.out_byte;
			m_data[10:8]  = r_q.byte_role;
			m_data[11]    = r_q.path_end;
			m_data[12]    = r_q.target_valid;
			m_data[28:13] = r_q.target_valid ? r_q.target_addr : 16'd0;
			m_data[29]    = r_q.range_warning;
			m_data[30]    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0; hi_q <= 1'b0;
		end else begin
			if (v_q && m_ready && hi_q) hi_q <= 1'b0;
			else if (in_valid && in_ready) begin
				v_q <= !hold_only; hi_q <= res.two;
			end else if (m_ready) v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk)
		if (in_valid && in_ready) r_q <= res;

	assert property (@(posedge clk) disable iff (!arst_n) hi_q |-> v_q)
		else $error("high half without item");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !m_ready |=> v_q) else $error("item dropped");

endmodule
